@@ design/lddf_pkg.sv @@
package lddf_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned MaxLenW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_DELIMITER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TERMINATOR_MODE = 2'd2;

  // Terminator modes; the unused code behaves as LF or CR LF.
  localparam logic [1:0] MODE_LF_OR_CRLF = 2'd0;
  localparam logic [1:0] MODE_LF_ONLY    = 2'd1;
  localparam logic [1:0] MODE_CRLF_ONLY  = 2'd2;

  localparam logic [MaxLenW-1:0] MAX_LENGTH_RESET = 16'hFFFF;

  typedef struct packed {
    logic [MaxLenW-1:0] max_length;
    logic               strip_delimiter;
    logic [1:0]         terminator_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       frame_end;
    logic       overflow;
  } res_t;

  // Results of one byte: count and up to two result items in order.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

@@ design/lddf_if.sv @@
interface lddf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lddf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       frame_end;
  logic       overflow;

  modport source (output valid, output out_byte, output has_byte, output frame_end,
                  output overflow, input ready);
  modport sink (input valid, input out_byte, input has_byte, input frame_end,
                input overflow, output ready);
endinterface

@@ design/lddf_core.sv @@
module lddf_core #(
  parameter int unsigned LENGTH_BITS = lddf_pkg::LengthBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [7:0]         byte_i,
  input  lddf_pkg::cfg_t     cfg_i,
  output lddf_pkg::step_t    step_o
);

  localparam int unsigned CmpW =
      (LENGTH_BITS > lddf_pkg::MaxLenW) ? LENGTH_BITS : lddf_pkg::MaxLenW;
  localparam logic [LENGTH_BITS-1:0] CountLimit = '1;

  typedef struct packed {
    logic cr;
    logic disc;
    logic clr;
  } disc_t;

  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic                   cr_q, cr_d;
  logic                   disc_q, disc_d;

  logic is_lf, is_cr, lf_ok, crlf_ok;

  assign is_lf   = (byte_i == lddf_pkg::LF_BYTE);
  assign is_cr   = (byte_i == lddf_pkg::CR_BYTE);
  assign lf_ok   = (cfg_i.terminator_mode != lddf_pkg::MODE_CRLF_ONLY);
  assign crlf_ok = (cfg_i.terminator_mode != lddf_pkg::MODE_LF_ONLY);

  function automatic disc_t discard_next(input logic cr, input logic lf, input logic crb,
                                         input logic lf_en, input logic crlf_en);
    disc_t r;
    r.cr   = 1'b0;
    r.disc = 1'b1;
    r.clr  = 1'b0;
    if ((cr && lf && crlf_en) || (lf && lf_en)) begin
      r.disc = 1'b0;
      r.clr  = 1'b1;
    end else if (crb && crlf_en) begin
      r.cr = 1'b1;
    end
    return r;
  endfunction

  function automatic logic too_long(input logic [LENGTH_BITS-1:0] cnt,
                                    input logic [lddf_pkg::MaxLenW-1:0] lim);
    return CmpW'(cnt) >= CmpW'(lim);
  endfunction

  always_comb begin
    lddf_pkg::res_t res [2];
    logic [1:0] n;
    logic       done;
    disc_t      dn;

    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    done    = 1'b0;
    count_d = count_q;
    cr_d    = cr_q;
    disc_d  = disc_q;
    dn      = '0;

    if (disc_q) begin
      dn     = discard_next(cr_q, is_lf, is_cr, lf_ok, crlf_ok);
      cr_d   = dn.cr;
      disc_d = dn.disc;
      if (dn.clr) count_d = '0;
    end else begin
      if (cr_q) begin
        cr_d = 1'b0;
        done = 1'b1;
        if (is_lf && crlf_ok) begin
          count_d = '0;
          if (cfg_i.strip_delimiter) begin
            res[0].frame_end = 1'b1;
            n = 2'd1;
          end else begin
            res[0].out_byte  = lddf_pkg::CR_BYTE;
            res[0].has_byte  = 1'b1;
            res[1].out_byte  = lddf_pkg::LF_BYTE;
            res[1].has_byte  = 1'b1;
            res[1].frame_end = 1'b1;
            n = 2'd2;
          end
        end else begin
          // The held CR turns out to be content.
          n = 2'd1;
          if (too_long(count_q, cfg_i.max_length)) begin
            count_d         = '0;
            disc_d          = 1'b1;
            res[0].overflow = 1'b1;
            dn     = discard_next(1'b0, is_lf, is_cr, lf_ok, crlf_ok);
            cr_d   = dn.cr;
            disc_d = dn.disc;
            if (dn.clr) count_d = '0;
          end else begin
            if (count_q < CountLimit) count_d = count_q + 1'b1;
            res[0].out_byte = lddf_pkg::CR_BYTE;
            res[0].has_byte = 1'b1;
            done = 1'b0;
          end
        end
      end

      if (!done) begin
        if (too_long(count_d, cfg_i.max_length)) begin
          // Any byte at or past the limit aborts, terminators included.
          count_d              = '0;
          cr_d                 = 1'b0;
          disc_d               = 1'b1;
          res[n[0]]            = '0;
          res[n[0]].overflow   = 1'b1;
          n                    = n + 2'd1;
        end else if (is_lf && lf_ok) begin
          count_d = '0;
          res[n[0]].frame_end = 1'b1;
          if (!cfg_i.strip_delimiter) begin
            res[n[0]].out_byte = lddf_pkg::LF_BYTE;
            res[n[0]].has_byte = 1'b1;
          end
          n = n + 2'd1;
        end else if (is_cr && crlf_ok) begin
          cr_d = 1'b1;
        end else begin
          if (count_d < CountLimit) count_d = count_d + 1'b1;
          res[n[0]].out_byte = byte_i;
          res[n[0]].has_byte = 1'b1;
          n = n + 2'd1;
        end
      end
    end

    step_o.num = n;
    step_o.r0  = res[0];
    step_o.r1  = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cr_q    <= 1'b0;
      disc_q  <= 1'b0;
    end else if (en_i) begin
      count_q <= count_d;
      cr_q    <= cr_d;
      disc_q  <= disc_d;
    end
  end

  a_disc_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (count_q == '0))
    else $error("content count not clear while discarding");

  // Two results always start with a forwarded CR.
  a_two_lead_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && step_o.num == 2'd2) |-> step_o.r0.has_byte)
    else $error("two results without a forwarded first byte");

endmodule

@@ design/lddf_obuf.sv @@
module lddf_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lddf_pkg::step_t   step_i,
  input  logic              ready_i,
  output logic              valid_o,
  output lddf_pkg::res_t    head_o,
  output logic              room_o
);

  logic [1:0]     cnt_q, cnt_d;
  lddf_pkg::res_t r0_q, r0_d;
  lddf_pkg::res_t r1_q, r1_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = r0_q;
  assign pop     = valid_o && ready_i;
  // New results may only land once the buffer drains completely this cycle.
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  always_comb begin
    cnt_d = cnt_q;
    r0_d  = r0_q;
    r1_d  = r1_q;
    if (load_i) begin
      cnt_d = step_i.num;
      r0_d  = step_i.r0;
      r1_d  = step_i.r1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      r0_d  = r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer holds more than two entries");

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> room_o)
    else $error("results loaded over undelivered ones");

endmodule

@@ design/line_delimiter_deframer.sv @@
// Channel   Role    Payload                                        Transfer
// in_i      sink    in_byte[7:0]                                   valid && ready
// out_o     source  out_byte[7:0], has_byte, frame_end, overflow   valid && ready
// cfg       write   cfg_we_i, cfg_idx_i[1:0], cfg_wdata_i[15:0]    cfg_we_i high
//
// One byte is taken per cycle while the result buffer has room. Each byte is held in
// the input register, its results in the two-entry result buffer. A byte giving two
// results fills the buffer and holds the input register until the last of them leaves.
// Reset clears the line state and sets max_length 65535, stripping on, mode 0.
// A stall on out_o backs up through the result buffer into the input register.
module line_delimiter_deframer #(
  parameter int unsigned LENGTH_BITS = lddf_pkg::LengthBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lddf_in_if.sink                       in_i,
  lddf_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [lddf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lddf_pkg::CfgDataW-1:0] cfg_wdata_i
);

  lddf_pkg::cfg_t  cfg_q;
  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            proc;
  logic            room;
  lddf_pkg::step_t step;
  lddf_pkg::res_t  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_length      <= lddf_pkg::MAX_LENGTH_RESET;
      cfg_q.strip_delimiter <= 1'b1;
      cfg_q.terminator_mode <= lddf_pkg::MODE_LF_OR_CRLF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lddf_pkg::CFG_MAX_LENGTH:      cfg_q.max_length      <= cfg_wdata_i;
        lddf_pkg::CFG_STRIP_DELIMITER: cfg_q.strip_delimiter <= cfg_wdata_i[0];
        lddf_pkg::CFG_TERMINATOR_MODE: cfg_q.terminator_mode <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign proc       = in_vld_q && room;
  assign in_i.ready = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_byte_q <= in_i.in_byte;
  end

  lddf_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .step_o (step)
  );

  lddf_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (proc),
    .step_i  (step),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .head_o  (head),
    .room_o  (room)
  );

  assign out_o.out_byte  = head.out_byte;
  assign out_o.has_byte  = head.has_byte;
  assign out_o.frame_end = head.frame_end;
  assign out_o.overflow  = head.overflow;

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("held input byte lost during a stall");

endmodule
